FILE: design/cbb_pkg.sv
// Shared types and codes for the clipped box blur block.
// No dependencies; the controller, datapath and top level refer to it by scoped name.
package cbb_pkg;

  // Register indexes on the configuration port
  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_RADIUS = 2'd2;

  // Request kinds
  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_DRAIN = 1'b1;

  typedef struct packed {
    logic       func;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [9:0] out_row;
    logic [9:0] out_column;
    logic       frame_last;
  } pix_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_RD,
    S_ACC,
    S_DINIT,
    S_DIV,
    S_EMIT
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic setup;
    logic rd;
    logic acc;
    logic dinit;
    logic dstep;
    logic emit;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic win_ready;
    logic win_last;
    logic div_done;
    logic out_full;
  } dp_status_t;

endpackage

FILE: design/cbb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cbb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/cbb_ctrl.sv
// Controller state machine for the clipped box blur block.
// Depends on cbb_pkg for the state, command and status types.
module cbb_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  cbb_pkg::dp_status_t status_i,
  output cbb_pkg::ctrl_cmd_t  cmd_o
);

  cbb_pkg::state_e state_q, state_d;

  // Hold the state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cbb_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Sequence one request: take it, test the window (back to idle if not ready), sum, divide, emit
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      cbb_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = cbb_pkg::S_CHECK;
        end
      end
      cbb_pkg::S_CHECK: begin
        if (status_i.win_ready) begin
          cmd_o.setup = 1'b1;
          state_d     = cbb_pkg::S_RD;
        end else begin
          state_d = cbb_pkg::S_IDLE;
        end
      end
      cbb_pkg::S_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = cbb_pkg::S_ACC;
      end
      cbb_pkg::S_ACC: begin
        cmd_o.acc = 1'b1;
        state_d   = status_i.win_last ? cbb_pkg::S_DINIT : cbb_pkg::S_RD;
      end
      cbb_pkg::S_DINIT: begin
        cmd_o.dinit = 1'b1;
        state_d     = cbb_pkg::S_DIV;
      end
      cbb_pkg::S_DIV: begin
        if (status_i.div_done) begin
          state_d = cbb_pkg::S_EMIT;
        end else begin
          cmd_o.dstep = 1'b1;
        end
      end
      cbb_pkg::S_EMIT: begin
        if (!status_i.out_full) begin
          cmd_o.emit = 1'b1;
          state_d    = cbb_pkg::S_IDLE;
        end
      end
      default: state_d = cbb_pkg::S_IDLE;
    endcase
  end

endmodule

FILE: design/cbb_datapath.sv
// Datapath of the clipped box blur: positions, pixel history, window sums,
// divider and output register. Depends on cbb_pkg and cbb_ram.
module cbb_datapath #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_RADIUS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cbb_pkg::ctrl_cmd_t  cmd_i,
  output cbb_pkg::dp_status_t status_o,
  input  cbb_pkg::pix_in_t    in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output cbb_pkg::pix_out_t   out_data_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [10:0]         cfg_wdata_i
);

  localparam int HR    = 2 * MAX_RADIUS + 2;
  localparam int DEPTH = HR * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int SLW   = $clog2(HR);
  localparam int PW    = $clog2(MAX_WIDTH + 1);
  localparam int PH    = $clog2(MAX_HEIGHT + 1);
  localparam int RDW   = $clog2(MAX_RADIUS + 1);
  localparam int RW    = $clog2(2 * MAX_RADIUS + 2);
  localparam int CW    = $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) + 1);
  localparam int SW    = CW + 8;
  localparam int DW    = CW + 1;
  localparam int NW    = CW + 9;
  localparam int KW    = $clog2(NW + 1);

  function automatic logic [SLW-1:0] slot_inc(input logic [SLW-1:0] s);
    return (s == SLW'(HR - 1)) ? '0 : s + SLW'(1);
  endfunction

  function automatic logic [AW-1:0] mem_addr(input logic [SLW-1:0] s,
                                             input logic [PW-1:0]  c);
    return AW'(s) * AW'(MAX_WIDTH) + AW'(c);
  endfunction

  // Configuration registers
  logic [10:0] w_cfg_q, h_cfg_q;
  logic [3:0]  r_cfg_q;
  logic        restart;

  assign restart = cfg_we_i && (cfg_idx_i == cbb_pkg::CFG_WIDTH ||
                   cfg_idx_i == cbb_pkg::CFG_HEIGHT || cfg_idx_i == cbb_pkg::CFG_RADIUS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_cfg_q <= 11'd1024;
      h_cfg_q <= 11'd1024;
      r_cfg_q <= 4'd2;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cbb_pkg::CFG_WIDTH:  w_cfg_q <= cfg_wdata_i;
        cbb_pkg::CFG_HEIGHT: h_cfg_q <= cfg_wdata_i;
        cbb_pkg::CFG_RADIUS: r_cfg_q <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  // Clamp the registers to the supported range
  logic [PW-1:0]  w;
  logic [PH-1:0]  h;
  logic [RDW-1:0] r;

  always_comb begin
    if (w_cfg_q == 11'd0)                  w = PW'(1);
    else if (32'(w_cfg_q) > MAX_WIDTH)     w = PW'(MAX_WIDTH);
    else                                   w = PW'(w_cfg_q);
    if (h_cfg_q == 11'd0)                  h = PH'(1);
    else if (32'(h_cfg_q) > MAX_HEIGHT)    h = PH'(MAX_HEIGHT);
    else                                   h = PH'(h_cfg_q);
    if (32'(r_cfg_q) > MAX_RADIUS)         r = RDW'(MAX_RADIUS);
    else                                   r = RDW'(r_cfg_q);
  end

  // Position state
  logic [PH-1:0]  in_row_q, in_row_d, out_row_q;
  logic [PW-1:0]  in_col_q, in_col_d, out_col_q;
  logic [SLW-1:0] in_slot_q, in_slot_d, out_slot_q;
  logic           frame_q, frame_d;
  logic           wr_en;
  logic [SLW-1:0] wr_slot;
  logic [PW-1:0]  wr_col;

  // Normalise a stale position, then store the pixel and advance
  always_comb begin
    in_row_d  = in_row_q;
    in_col_d  = in_col_q;
    in_slot_d = in_slot_q;
    frame_d   = frame_q;
    if (in_col_d >= w) begin
      in_col_d  = '0;
      in_row_d  = in_row_d + PH'(1);
      in_slot_d = slot_inc(in_slot_d);
    end
    if (!frame_d && in_row_d >= h) begin
      frame_d   = 1'b1;
      in_row_d  = '0;
      in_col_d  = '0;
      in_slot_d = '0;
    end
    wr_slot = in_slot_d;
    wr_col  = in_col_d;
    wr_en   = cmd_i.accept && in_data_i.func == cbb_pkg::FUNC_PIXEL && !frame_d;
    if (in_data_i.func == cbb_pkg::FUNC_PIXEL && !frame_d) begin
      in_col_d = in_col_d + PW'(1);
      if (in_col_d >= w) begin
        in_col_d  = '0;
        in_row_d  = in_row_d + PH'(1);
        in_slot_d = slot_inc(in_slot_d);
        if (in_row_d >= h) begin
          in_row_d  = '0;
          in_slot_d = '0;
          frame_d   = 1'b1;
        end
      end
    end
  end

  // Window bounds for the next output
  logic [PH:0]    need_r_sum;
  logic [PW:0]    need_c_sum;
  logic [PH-1:0]  need_r, r_lo;
  logic [PW-1:0]  need_c, c_lo;
  logic [SLW-1:0] dr, start_slot;
  logic [RW-1:0]  rows, cols;
  logic           win_ok, ready_now;

  always_comb begin
    need_r_sum = (PH+1)'(out_row_q) + (PH+1)'(r);
    need_c_sum = (PW+1)'(out_col_q) + (PW+1)'(r);
    need_r = (need_r_sum < (PH+1)'(h - PH'(1))) ? PH'(need_r_sum) : h - PH'(1);
    need_c = (need_c_sum < (PW+1)'(w - PW'(1))) ? PW'(need_c_sum) : w - PW'(1);
    if ((PH+1)'(out_row_q) > (PH+1)'(r)) begin
      r_lo = out_row_q - PH'(r);
      dr   = SLW'(r);
    end else begin
      r_lo = '0;
      dr   = SLW'(out_row_q);
    end
    c_lo = ((PW+1)'(out_col_q) > (PW+1)'(r)) ? out_col_q - PW'(r) : '0;
    start_slot = (out_slot_q >= dr) ? out_slot_q - dr : out_slot_q + SLW'(HR) - dr;
    rows = RW'(need_r - r_lo) + RW'(1);
    cols = RW'(need_c - c_lo) + RW'(1);
    win_ok    = out_row_q < h && out_col_q < w;
    ready_now = frame_q || in_row_q > need_r || (in_row_q == need_r && in_col_q > need_c);
  end

  // Window walk, sums and divider registers
  logic [PH-1:0]  y_q, r_hi_q;
  logic [PW-1:0]  x_q, c_lo_q, c_hi_q;
  logic [SLW-1:0] ys_q;
  logic [SW-1:0]  sum_q [3];
  logic [CW-1:0]  cnt_q;
  logic [NW-1:0]  num_q [3];
  logic [DW-1:0]  rem_q [3];
  logic [KW-1:0]  dcnt_q;
  logic [23:0]    rdata;
  logic [DW-1:0]  den;
  logic [DW:0]    shifted [3];
  logic           fits [3];

  assign den = {cnt_q, 1'b0};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      shifted[i] = {rem_q[i], num_q[i][NW-1]};
      fits[i]    = shifted[i] >= {1'b0, den};
    end
  end

  cbb_ram #(
    .WIDTH(24),
    .DEPTH(DEPTH)
  ) u_hist (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(mem_addr(wr_slot, wr_col)),
    .wdata_i({in_data_i.blue_in, in_data_i.green_in, in_data_i.red_in}),
    .re_i   (cmd_i.rd),
    .raddr_i(mem_addr(ys_q, x_q)),
    .rdata_o(rdata)
  );

  // Walk the window and run the divider; payload needs no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      y_q    <= r_lo;
      x_q    <= c_lo;
      ys_q   <= start_slot;
      c_lo_q <= c_lo;
      c_hi_q <= need_c;
      r_hi_q <= need_r;
      cnt_q  <= CW'(rows) * CW'(cols);
      for (int i = 0; i < 3; i++) sum_q[i] <= '0;
    end
    if (cmd_i.acc) begin
      sum_q[0] <= sum_q[0] + SW'(rdata[7:0]);
      sum_q[1] <= sum_q[1] + SW'(rdata[15:8]);
      sum_q[2] <= sum_q[2] + SW'(rdata[23:16]);
      if (x_q == c_hi_q) begin
        x_q  <= c_lo_q;
        y_q  <= y_q + PH'(1);
        ys_q <= slot_inc(ys_q);
      end else begin
        x_q <= x_q + PW'(1);
      end
    end
    if (cmd_i.dinit) begin
      for (int i = 0; i < 3; i++) begin
        num_q[i] <= {sum_q[i], 1'b0} + NW'(cnt_q);
        rem_q[i] <= '0;
      end
      dcnt_q <= KW'(NW);
    end
    if (cmd_i.dstep) begin
      for (int i = 0; i < 3; i++) begin
        rem_q[i] <= fits[i] ? DW'(shifted[i] - {1'b0, den}) : DW'(shifted[i]);
        num_q[i] <= {num_q[i][NW-2:0], fits[i]};
      end
      dcnt_q <= dcnt_q - KW'(1);
    end
  end

  // Output register
  logic     last;
  cbb_pkg::pix_out_t out_q;
  logic     out_valid_q;

  assign last = out_row_q == h - PH'(1) && out_col_q == w - PW'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q.red_out    <= num_q[0][7:0];
      out_q.green_out  <= num_q[1][7:0];
      out_q.blue_out   <= num_q[2][7:0];
      out_q.out_row    <= 10'(out_row_q);
      out_q.out_column <= 10'(out_col_q);
      out_q.frame_last <= last;
    end
  end

  // Control state: positions, frame flag, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_row_q    <= '0;
      in_col_q    <= '0;
      in_slot_q   <= '0;
      frame_q     <= 1'b0;
      out_row_q   <= '0;
      out_col_q   <= '0;
      out_slot_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (restart || (cmd_i.emit && last)) begin
        in_row_q   <= '0;
        in_col_q   <= '0;
        in_slot_q  <= '0;
        frame_q    <= 1'b0;
        out_row_q  <= '0;
        out_col_q  <= '0;
        out_slot_q <= '0;
      end else begin
        if (cmd_i.accept) begin
          in_row_q  <= in_row_d;
          in_col_q  <= in_col_d;
          in_slot_q <= in_slot_d;
          frame_q   <= frame_d;
        end
        if (cmd_i.emit) begin
          if (out_col_q + PW'(1) >= w) begin
            out_col_q  <= '0;
            out_row_q  <= out_row_q + PH'(1);
            out_slot_q <= slot_inc(out_slot_q);
          end else begin
            out_col_q <= out_col_q + PW'(1);
          end
        end
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end
    end
  end

  assign status_o.win_ready = win_ok && ready_now;
  assign status_o.win_last  = x_q == c_hi_q && y_q == r_hi_q;
  assign status_o.div_done  = dcnt_q == '0;
  assign status_o.out_full  = out_valid_q;
  assign out_valid_o        = out_valid_q;
  assign out_data_o         = out_q;

endmodule

FILE: design/clipped_box_blur_rgb_top.sv
// Clipped RGB box blur. A request that completes a window walks the window,
// reading each window pixel over the single history read port, then runs a
// bit-serial divider over NW bits (18 at radius 8) before its result shows.
// One request at a time: a new request is taken only back in idle. Reset
// clears positions, the frame flag and output valid; the pixel history is
// left unset and is never read unwritten.
module clipped_box_blur_rgb_top #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_RADIUS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cbb_pkg::pix_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output cbb_pkg::pix_out_t out_data_o,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [10:0]       cfg_wdata_i
);

  cbb_pkg::ctrl_cmd_t  cmd;
  cbb_pkg::dp_status_t status;

  cbb_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  cbb_datapath #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_RADIUS(MAX_RADIUS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // One request in flight: none taken in the cycle after one is taken
  a_one_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request taken while another is in flight");

  // A result appears only from an emit command
  a_emit_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.emit))
    else $error("result raised without emit");

  // Emit never overwrites a waiting result
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> !out_valid_o)
    else $error("emit while result still waiting");

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for clipped_box_blur_rgb_top: a directed table, then random frames.
// Depends on cbb_pkg and the top level. A local box-mean model predicts each result not typed into the table.
module testbench;

  localparam int HIST_ROWS  = 18;
  localparam int MAXW       = 1024;
  localparam int MAXH       = 1024;
  localparam int MAXR       = 8;
  localparam int DRAIN_WAIT = 700;
  localparam int IDLE_LIMIT = 5000;
  localparam int N_DIR      = 24;
  localparam int N_ITEMS    = 800;

  typedef struct packed {
    logic              is_cfg;
    logic [1:0]        idx;
    logic [10:0]       val;
    cbb_pkg::pix_in_t  req;
    logic              known;
    cbb_pkg::pix_out_t want;
  } step_t;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  cbb_pkg::pix_in_t  in_data_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b1;
  cbb_pkg::pix_out_t out_data_o;
  logic              cfg_we_i = 1'b0;
  logic [1:0]        cfg_idx_i = '0;
  logic [10:0]       cfg_wdata_i = '0;

  // Model state
  logic [23:0] hist_px [0:HIST_ROWS*MAXW-1];
  int unsigned reg_w, reg_h, reg_r;
  int unsigned in_row, in_col, out_row, out_col;
  bit          frame_full;

  cbb_pkg::pix_out_t blur_due[$];
  int          n_fail = 0;
  int          n_sent = 0;
  int          idle_cycles = 0;
  int          stall_left = 0;
  bit          gaps_on = 1'b0;
  bit          stalls_on = 1'b0;

  clipped_box_blur_rgb_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int unsigned clampu(int unsigned v, int unsigned lo, int unsigned hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic void restart_frame();
    in_row = 0;
    in_col = 0;
    out_row = 0;
    out_col = 0;
    frame_full = 1'b0;
  endfunction

  // Advance the model by one request; return the box mean that leaves, if any
  function automatic bit blur_step(input cbb_pkg::pix_in_t req,
                                   output cbb_pkg::pix_out_t res);
    int unsigned w, h, r, need_r, need_c, r_lo, c_lo, y, x;
    longint unsigned sr, sg, sb, cnt;
    logic [23:0] px;
    bit last;
    w = clampu(reg_w, 1, MAXW);
    h = clampu(reg_h, 1, MAXH);
    r = clampu(reg_r, 0, MAXR);
    sr = 0;
    sg = 0;
    sb = 0;
    res = '0;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    if (!frame_full && in_row >= h) begin
      frame_full = 1'b1;
      in_row = 0;
      in_col = 0;
    end
    // Store the pixel unless the frame is already complete
    if (req.func == cbb_pkg::FUNC_PIXEL && !frame_full) begin
      hist_px[(in_row % HIST_ROWS) * MAXW + in_col] = {req.blue_in, req.green_in, req.red_in};
      if (++in_col >= w) begin
        in_col = 0;
        if (++in_row >= h) begin
          in_row = 0;
          frame_full = 1'b1;
        end
      end
    end
    if (out_row >= h || out_col >= w) return 1'b0;
    need_r = out_row + r < h - 1 ? out_row + r : h - 1;
    need_c = out_col + r < w - 1 ? out_col + r : w - 1;
    if (!(frame_full || in_row > need_r || (in_row == need_r && in_col > need_c)))
      return 1'b0;
    r_lo = out_row > r ? out_row - r : 0;
    c_lo = out_col > r ? out_col - r : 0;
    for (y = r_lo; y <= need_r; y++) begin
      for (x = c_lo; x <= need_c; x++) begin
        px = hist_px[(y % HIST_ROWS) * MAXW + x];
        sr += px[7:0];
        sg += px[15:8];
        sb += px[23:16];
      end
    end
    cnt = longint'(need_r - r_lo + 1) * longint'(need_c - c_lo + 1);
    last = (out_row == h - 1) && (out_col == w - 1);
    res.red_out    = 8'((2 * sr + cnt) / (2 * cnt));
    res.green_out  = 8'((2 * sg + cnt) / (2 * cnt));
    res.blue_out   = 8'((2 * sb + cnt) / (2 * cnt));
    res.out_row    = 10'(out_row);
    res.out_column = 10'(out_col);
    res.frame_last = last;
    if (last) begin
      restart_frame();
    end else if (++out_col >= w) begin
      out_col = 0;
      out_row++;
    end
    return 1'b1;
  endfunction

  // Hold until every expected result has left, then let the block finish any walk
  task automatic settle();
    while (blur_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic set_reg(input logic [1:0] idx, input logic [10:0] val);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      cbb_pkg::CFG_WIDTH:  reg_w = val;
      cbb_pkg::CFG_HEIGHT: reg_h = val;
      cbb_pkg::CFG_RADIUS: reg_r = val[3:0];
      default: ;
    endcase
    restart_frame();
  endtask

  // Offer one request; queue its prediction (or the typed-in value) once accepted
  task automatic send_req(input cbb_pkg::pix_in_t req, input bit known,
                          input cbb_pkg::pix_out_t want);
    cbb_pkg::pix_out_t res;
    bit has;
    if (gaps_on && n_sent < 700 && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    in_data_i = req;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    has = blur_step(req, res);
    if (known) blur_due.push_back(want);
    else if (has) blur_due.push_back(res);
    n_sent++;
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  function automatic cbb_pkg::pix_in_t rand_px();
    cbb_pkg::pix_in_t p;
    p.func = cbb_pkg::FUNC_PIXEL;
    case ($urandom_range(0, 5))
      0: {p.red_in, p.green_in, p.blue_in} = 24'h000000;
      1: {p.red_in, p.green_in, p.blue_in} = 24'hffffff;
      default: {p.red_in, p.green_in, p.blue_in} = 24'($urandom);
    endcase
    return p;
  endfunction

  function automatic cbb_pkg::pix_in_t drain_req();
    cbb_pkg::pix_in_t p;
    p = cbb_pkg::pix_in_t'(25'($urandom));
    p.func = cbb_pkg::FUNC_DRAIN;
    return p;
  endfunction

  task automatic chk_field(input string nm, input logic [9:0] want, input logic [9:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, nm, want, got);
      n_fail++;
    end
  endtask

  // Compare each result with the oldest expectation
  always @(posedge clk_i) begin
    cbb_pkg::pix_out_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (blur_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, out_data_o);
        n_fail++;
      end else begin
        e = blur_due.pop_front();
        chk_field("red_out", e.red_out, out_data_o.red_out);
        chk_field("green_out", e.green_out, out_data_o.green_out);
        chk_field("blue_out", e.blue_out, out_data_o.blue_out);
        chk_field("out_row", e.out_row, out_data_o.out_row);
        chk_field("out_column", e.out_column, out_data_o.out_column);
        chk_field("frame_last", e.frame_last, out_data_o.frame_last);
      end
    end
  end

  // Drop ready in random bursts
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready_i = 1'b0;
    end else if (stalls_on && n_sent < 700 && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 9) - 1;
      out_ready_i = 1'b0;
    end else begin
      out_ready_i = 1'b1;
    end
  end

  // Watchdog on cycles with no request or result moving
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    step_t dir_tab [0:N_DIR-1];
    cbb_pkg::pix_out_t nil;
    int unsigned w_eff, h_eff, k, nfr, f;
    bit cut, pressed;
    nil = '0;
    pressed = 1'b0;
    dir_tab = '{
      '{1'b1, cbb_pkg::CFG_WIDTH,  11'd1, 25'h0, 1'b0, 45'h0},
      '{1'b1, cbb_pkg::CFG_HEIGHT, 11'd1, 25'h0, 1'b0, 45'h0},
      '{1'b1, cbb_pkg::CFG_RADIUS, 11'd0, 25'h0, 1'b0, 45'h0},
      '{1'b0, 2'd0, 11'd0, {cbb_pkg::FUNC_PIXEL, 24'hff0080}, 1'b1,
        {24'hff0080, 10'd0, 10'd0, 1'b1}},
      '{1'b0, 2'd0, 11'd0, {cbb_pkg::FUNC_DRAIN, 24'h123456}, 1'b0, 45'h0},
      '{1'b0, 2'd0, 11'd0, {cbb_pkg::FUNC_PIXEL, 24'h00ff7f}, 1'b1,
        {24'h00ff7f, 10'd0, 10'd0, 1'b1}},
      '{1'b1, cbb_pkg::CFG_WIDTH,  11'd2, 25'h0, 1'b0, 45'h0},
      '{1'b1, cbb_pkg::CFG_HEIGHT, 11'd1, 25'h0, 1'b0, 45'h0},
      '{1'b1, cbb_pkg::CFG_RADIUS, 11'd1, 25'h0, 1'b0, 45'h0},
      // ties round up: means of 0.5, 127.5 and 127
      '{1'b0, 2'd0, 11'd0, {cbb_pkg::FUNC_PIXEL, 24'h000000}, 1'b0, 45'h0},
      '{1'b0, 2'd0, 11'd0, {cbb_pkg::FUNC_PIXEL, 24'h01fffe}, 1'b1,
        {24'h01807f, 10'd0, 10'd0, 1'b0}},
      '{1'b0, 2'd0, 11'd0, {cbb_pkg::FUNC_DRAIN, 24'h0}, 1'b1,
        {24'h01807f, 10'd0, 10'd1, 1'b1}},
      '{1'b1, cbb_pkg::CFG_WIDTH,  11'd2, 25'h0, 1'b0, 45'h0},
      '{1'b1, cbb_pkg::CFG_HEIGHT, 11'd2, 25'h0, 1'b0, 45'h0},
      '{1'b1, cbb_pkg::CFG_RADIUS, 11'd8, 25'h0, 1'b0, 45'h0},
      '{1'b0, 2'd0, 11'd0, {cbb_pkg::FUNC_PIXEL, 24'hffffff}, 1'b0, 45'h0},
      '{1'b0, 2'd0, 11'd0, {cbb_pkg::FUNC_PIXEL, 24'h102030}, 1'b0, 45'h0},
      '{1'b0, 2'd0, 11'd0, {cbb_pkg::FUNC_PIXEL, 24'h00ff00}, 1'b0, 45'h0},
      '{1'b0, 2'd0, 11'd0, {cbb_pkg::FUNC_PIXEL, 24'h7f0180}, 1'b0, 45'h0},
      // a pixel after a complete frame only lets outputs leave
      '{1'b0, 2'd0, 11'd0, {cbb_pkg::FUNC_PIXEL, 24'haaaaaa}, 1'b0, 45'h0},
      '{1'b0, 2'd0, 11'd0, {cbb_pkg::FUNC_DRAIN, 24'hffffff}, 1'b0, 45'h0},
      '{1'b0, 2'd0, 11'd0, {cbb_pkg::FUNC_DRAIN, 24'h0}, 1'b0, 45'h0},
      '{1'b0, 2'd0, 11'd0, {cbb_pkg::FUNC_DRAIN, 24'h0}, 1'b0, 45'h0},
      '{1'b0, 2'd0, 11'd0, {cbb_pkg::FUNC_DRAIN, 24'h0}, 1'b0, 45'h0}
    };
    reg_w = 1024;
    reg_h = 1024;
    reg_r = 2;
    restart_frame();
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed table
    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) begin
        settle();
        set_reg(dir_tab[i].idx, dir_tab[i].val);
      end else begin
        send_req(dir_tab[i].req, dir_tab[i].known, dir_tab[i].want);
      end
    end

    // Clamped extremes, each a partial frame abandoned by the next write
    for (f = 0; f < 2; f++) begin
      settle();
      set_reg(cbb_pkg::CFG_WIDTH, f == 0 ? 11'd2047 : 11'd1);
      set_reg(cbb_pkg::CFG_HEIGHT, f == 0 ? 11'd0 : 11'd1024);
      set_reg(cbb_pkg::CFG_RADIUS, 11'd15);
      repeat (f == 0 ? 40 : 30) send_req(rand_px(), 1'b0, nil);
      repeat (20) send_req(drain_req(), 1'b0, nil);
    end

    // Random frames under random settings
    while (n_sent < N_ITEMS) begin
      settle();
      set_reg(cbb_pkg::CFG_WIDTH,
              $urandom_range(0, 9) == 0 ? 11'd0 : 11'($urandom_range(1, 24)));
      set_reg(cbb_pkg::CFG_HEIGHT, 11'($urandom_range(1, 10)));
      set_reg(cbb_pkg::CFG_RADIUS,
              $urandom_range(0, 9) == 0 ? 11'd15 : 11'($urandom_range(0, 9)));
      gaps_on = $urandom_range(0, 2) != 0;
      stalls_on = $urandom_range(0, 2) != 0;
      w_eff = clampu(reg_w, 1, MAXW);
      h_eff = clampu(reg_h, 1, MAXH);
      nfr = $urandom_range(1, 2);
      cut = 1'b0;
      for (f = 0; f < nfr && !cut; f++) begin
        for (k = 0; k < w_eff * h_eff; k++) begin
          if ($urandom_range(0, 7) == 0) send_req(drain_req(), 1'b0, nil);
          // abandon the frame at random, or once enough requests have gone
          if (n_sent >= N_ITEMS || $urandom_range(0, 59) == 0) begin
            cut = 1'b1;
            break;
          end
          send_req(rand_px(), 1'b0, nil);
        end
        // flush the tail, sometimes with pixels that are dropped
        while (frame_full)
          send_req($urandom_range(0, 2) == 0 ? rand_px() : drain_req(), 1'b0, nil);
        if (!pressed && n_sent > 400) begin
          while (blur_due.size() != 0) @(posedge clk_i);
          @(negedge clk_i);
          pressed = 1'b1;
        end
      end
      if (cut) repeat ($urandom_range(1, 5)) send_req(drain_req(), 1'b0, nil);
    end

    while (blur_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (n_fail == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
